/* rtl/triangle_tangent_frame_unit_defines.svh */
// ----------------------------------------------------------------------------
// triangle tangent frame unit assertion macros
// shared property wrappers, clocked on clk and disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_TANGENT_FRAME_UNIT_DEFINES_SVH
`define TRIANGLE_TANGENT_FRAME_UNIT_DEFINES_SVH

// same-cycle implication
`define TTF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TTF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/ttf_pkg.sv */
// ----------------------------------------------------------------------------
// ttf_pkg
// widths, payload types and shared constants of the tangent frame unit
// ----------------------------------------------------------------------------
package ttf_pkg;

  localparam int COORD_W     = 32;
  localparam int UNIT_W      = 16;
  localparam int FRAC_W      = UNIT_W - 2;
  localparam int EDGE_W      = COORD_W + 1;
  localparam int MUL_W       = (EDGE_W > 2 * UNIT_W - 1) ? EDGE_W : 2 * UNIT_W - 1;
  localparam int RAW_W       = 2 * MUL_W + 1;
  localparam int NORM_W      = 30;
  localparam int SQ_W        = 2 * NORM_W + 2;
  localparam int DIV_W       = NORM_W + FRAC_W + 3;
  localparam int CORNERS     = 3;
  localparam int QUEUE_DEPTH = 2;
  localparam int UNIT_ONE    = 1 << FRAC_W;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [EDGE_W-1:0]  edge_t;
  typedef logic signed [UNIT_W-1:0]  unit_t;
  typedef logic signed [MUL_W-1:0]   mop_t;
  typedef logic signed [RAW_W-1:0]   raw_t;

  typedef struct packed {
    coord_t pos_x;
    coord_t pos_y;
    coord_t pos_z;
    coord_t tex_u;
    coord_t tex_v;
  } ttf_in_t;

  typedef struct packed {
    logic [1:0] corner;
    logic       last;
    unit_t      norm_x;
    unit_t      norm_y;
    unit_t      norm_z;
    unit_t      tan_x;
    unit_t      tan_y;
    unit_t      tan_z;
    unit_t      bin_x;
    unit_t      bin_y;
    unit_t      bin_z;
  } ttf_out_t;

  typedef ttf_in_t [CORNERS-1:0] ttf_tri_t;

endpackage

/* rtl/ttf_front.sv */
// ----------------------------------------------------------------------------
// ttf_front
// vertex capture: holds the first two vertices and forms a triangle
// ----------------------------------------------------------------------------
module ttf_front import ttf_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  ttf_in_t  in_data,
  output logic     tri_push,
  output ttf_tri_t tri_data,
  input  logic     q_full
);

  localparam logic [1:0] SLOT_FIRST  = 2'd0;
  localparam logic [1:0] SLOT_SECOND = 2'd1;
  localparam logic [1:0] SLOT_THIRD  = 2'd2;

  logic [1:0] slot_r, slot_nxt;
  ttf_in_t    held0_r, held1_r;
  logic       take;

  // only the closing vertex needs room in the queue
  assign in_stall = (slot_r == SLOT_THIRD) && q_full;
  assign take     = in_valid && !in_stall;
  assign tri_push = take && (slot_r == SLOT_THIRD);
  assign tri_data = {in_data, held1_r, held0_r};

  always_comb begin
    slot_nxt = slot_r;
    if (take) begin
      slot_nxt = (slot_r == SLOT_THIRD) ? SLOT_FIRST : slot_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= SLOT_FIRST;
    end else begin
      slot_r <= slot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take && slot_r == SLOT_FIRST) begin
      held0_r <= in_data;
    end
    if (take && slot_r == SLOT_SECOND) begin
      held1_r <= in_data;
    end
  end

endmodule

/* rtl/ttf_queue.sv */
// ----------------------------------------------------------------------------
// ttf_queue
// short triangle queue between vertex capture and the frame engine
// ----------------------------------------------------------------------------
`include "triangle_tangent_frame_unit_defines.svh"

module ttf_queue import ttf_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  ttf_tri_t push_data,
  output logic     full,
  input  logic     pop,
  output logic     head_valid,
  output ttf_tri_t head_data
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  ttf_tri_t         mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full       = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_data  = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  `TTF_ASSERT_NOW(a_no_push_full, push, !full || pop, "triangle pushed into a full queue")
  `TTF_ASSERT_NOW(a_no_pop_empty, pop, head_valid, "triangle popped from an empty queue")
  `TTF_ASSERT_NEXT(a_fill_grows, push && !pop, cnt_r == $past(cnt_r) + CNT_W'(1),
                   "queue fill did not grow on a lone push")

endmodule

/* rtl/ttf_norm.sv */
// ----------------------------------------------------------------------------
// ttf_norm
// serial vector normaliser: leading-zero shift, squares, bit-serial root,
// three-lane restoring divide, rounded to signed unit fixed point
// ----------------------------------------------------------------------------
`include "triangle_tangent_frame_unit_defines.svh"

module ttf_norm import ttf_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  input  raw_t  vec_in   [CORNERS],
  output logic  done,
  output unit_t unit_out [CORNERS]
);

  localparam logic [2:0] N_IDLE  = 3'd0;
  localparam logic [2:0] N_SHIFT = 3'd1;
  localparam logic [2:0] N_SQR   = 3'd2;
  localparam logic [2:0] N_ROOT  = 3'd3;
  localparam logic [2:0] N_DIV   = 3'd4;
  localparam logic [2:0] N_DONE  = 3'd5;

  localparam int CNT_W  = $clog2(NORM_W + 2);
  localparam int SH_BIG = 16;
  localparam int SH_MID = 4;
  localparam logic [SQ_W-1:0] ROOT_BIT = {2'b01, {(SQ_W - 2){1'b0}}};

  logic [2:0]          state_r, state_nxt;
  logic [CNT_W-1:0]    cnt_r;
  logic                sgn_r  [CORNERS];
  logic [RAW_W-1:0]    mag_r  [CORNERS];
  logic [NORM_W-1:0]   m_w    [CORNERS];
  logic [2*NORM_W-1:0] prod_r;
  logic [SQ_W-1:0]     sum_r, s_r, res_r, bit_r;
  logic [SQ_W-1:0]     root_try, res_nxt;
  logic                root_ge;
  logic [DIV_W-1:0]    rem_r  [CORNERS];
  logic [DIV_W-1:0]    dvs_r;
  logic [FRAC_W:0]     q_r    [CORNERS];
  logic [FRAC_W:0]     q_nxt  [CORNERS];
  logic                div_ge [CORNERS];
  unit_t               unit_r [CORNERS];
  logic [RAW_W-1:0]    orv;
  logic                in_zero;
  logic [NORM_W-1:0]   msel;

  assign done = (state_r == N_DONE);

  always_comb begin
    orv     = mag_r[0] | mag_r[1] | mag_r[2];
    in_zero = ((vec_in[0] | vec_in[1] | vec_in[2]) == '0);
    for (int i = 0; i < CORNERS; i++) begin
      m_w[i]      = mag_r[i][RAW_W-1 -: NORM_W];
      unit_out[i] = unit_r[i];
      div_ge[i]   = (rem_r[i] >= dvs_r);
      q_nxt[i]    = {q_r[i][FRAC_W-1:0], div_ge[i]};
    end
    root_try = res_r + bit_r;
    root_ge  = (s_r >= root_try);
    res_nxt  = root_ge ? (res_r >> 1) + bit_r : (res_r >> 1);
    unique case (cnt_r[1:0])
      2'd0:    msel = m_w[0];
      2'd1:    msel = m_w[1];
      default: msel = m_w[2];
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      N_IDLE:  if (start) state_nxt = in_zero ? N_DONE : N_SHIFT;
      N_SHIFT: if (orv[RAW_W-1]) state_nxt = N_SQR;
      N_SQR:   if (cnt_r == CNT_W'(CORNERS)) state_nxt = N_ROOT;
      N_ROOT:  if (cnt_r == CNT_W'(NORM_W)) state_nxt = N_DIV;
      N_DIV:   if (cnt_r == CNT_W'(FRAC_W)) state_nxt = N_DONE;
      N_DONE:  state_nxt = N_IDLE;
      default: state_nxt = N_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= N_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      N_IDLE: begin
        if (start) begin
          for (int i = 0; i < CORNERS; i++) begin
            sgn_r[i]  <= vec_in[i][RAW_W-1];
            mag_r[i]  <= vec_in[i][RAW_W-1] ? RAW_W'(-vec_in[i]) : RAW_W'(vec_in[i]);
            unit_r[i] <= '0;
          end
        end
      end
      N_SHIFT: begin
        // coarse then fine steps until the largest magnitude reaches the top bit
        if (!orv[RAW_W-1]) begin
          for (int i = 0; i < CORNERS; i++) begin
            if (orv[RAW_W-1 -: SH_BIG] == '0) begin
              mag_r[i] <= mag_r[i] << SH_BIG;
            end else if (orv[RAW_W-1 -: SH_MID] == '0) begin
              mag_r[i] <= mag_r[i] << SH_MID;
            end else begin
              mag_r[i] <= mag_r[i] << 1;
            end
          end
        end
        cnt_r <= '0;
      end
      N_SQR: begin
        if (cnt_r != CNT_W'(CORNERS)) begin
          prod_r <= msel * msel;
        end
        sum_r <= (cnt_r == '0) ? '0 : sum_r + SQ_W'(prod_r);
        if (cnt_r == CNT_W'(CORNERS)) begin
          s_r   <= sum_r + SQ_W'(prod_r);
          res_r <= '0;
          bit_r <= ROOT_BIT;
          cnt_r <= '0;
        end else begin
          cnt_r <= cnt_r + CNT_W'(1);
        end
      end
      N_ROOT: begin
        s_r   <= root_ge ? s_r - root_try : s_r;
        res_r <= res_nxt;
        bit_r <= bit_r >> 2;
        if (cnt_r == CNT_W'(NORM_W)) begin
          // numerator carries half the divisor for round half away from zero
          for (int i = 0; i < CORNERS; i++) begin
            rem_r[i] <= (DIV_W'(m_w[i]) << (FRAC_W + 1)) + DIV_W'(res_nxt[NORM_W:0]);
            q_r[i]   <= '0;
          end
          dvs_r <= DIV_W'(res_nxt[NORM_W:0]) << (FRAC_W + 1);
          cnt_r <= '0;
        end else begin
          cnt_r <= cnt_r + CNT_W'(1);
        end
      end
      N_DIV: begin
        for (int i = 0; i < CORNERS; i++) begin
          rem_r[i] <= div_ge[i] ? rem_r[i] - dvs_r : rem_r[i];
          q_r[i]   <= q_nxt[i];
          if (cnt_r == CNT_W'(FRAC_W)) begin
            unit_r[i] <= sgn_r[i] ? -unit_t'(q_nxt[i]) : unit_t'(q_nxt[i]);
          end
        end
        dvs_r <= dvs_r >> 1;
        cnt_r <= cnt_r + CNT_W'(1);
      end
      default: begin
      end
    endcase
  end

  `TTF_ASSERT_NOW(a_start_idle, start, state_r == N_IDLE, "normaliser started while busy")
  `TTF_ASSERT_NOW(a_unit_range, done,
                  unit_r[0] <= UNIT_ONE && unit_r[0] >= -UNIT_ONE &&
                  unit_r[1] <= UNIT_ONE && unit_r[1] >= -UNIT_ONE &&
                  unit_r[2] <= UNIT_ONE && unit_r[2] >= -UNIT_ONE,
                  "unit component beyond one")

endmodule

/* rtl/ttf_back.sv */
// ----------------------------------------------------------------------------
// ttf_back
// frame engine: edge set-up, shared multiply-accumulate for the raw vectors,
// handedness test, normaliser sequencing and the output register
// ----------------------------------------------------------------------------
`include "triangle_tangent_frame_unit_defines.svh"

module ttf_back import ttf_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     tri_valid,
  input  ttf_tri_t tri_data,
  output logic     tri_pop,
  output logic     out_valid,
  input  logic     out_stall,
  output ttf_out_t out_data
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EDGE   = 3'd1;
  localparam logic [2:0] S_RAW    = 3'd2;
  localparam logic [2:0] S_NSTART = 3'd3;
  localparam logic [2:0] S_NWAIT  = 3'd4;
  localparam logic [2:0] S_CROSS  = 3'd5;
  localparam logic [2:0] S_DOT    = 3'd6;
  localparam logic [2:0] S_FIN    = 3'd7;

  localparam logic [1:0] DST_RAW   = 2'd0;
  localparam logic [1:0] DST_CROSS = 2'd1;
  localparam logic [1:0] DST_DOT   = 2'd2;

  localparam logic [1:0] CORNER_LAST = 2'd2;
  localparam int RAW_VECS = 3 * CORNERS;
  localparam int RAW_STEPS = 2 * RAW_VECS;
  localparam int STEP_W = $clog2(RAW_STEPS);

  typedef struct packed {
    logic       valid;
    logic       first;
    logic       sub;
    logic       store;
    logic [1:0] dest;
  } mac_ctl_t;

  logic [2:0]        state_r, state_nxt;
  logic [1:0]        corner_r;
  logic [1:0]        nidx_r;
  logic [STEP_W-1:0] step_r;
  edge_t             e1_r [CORNERS];
  edge_t             e2_r [CORNERS];
  edge_t             du1_r, du2_r, dv1_r, dv2_r;
  raw_t              raw_r [RAW_VECS];
  unit_t             res_r [RAW_VECS];
  mop_t              c_r   [CORNERS];
  logic              neg_r;
  logic signed [2*MUL_W-1:0] prod_r;
  mac_ctl_t          pend_r, iss;
  raw_t              acc_r, acc_nxt, term;
  mop_t              opa, opb;
  ttf_out_t          out_r;
  logic              out_valid_r;
  ttf_in_t           vp, vq, vr;
  logic              norm_start, norm_done, out_free, out_load;
  raw_t              norm_vec  [CORNERS];
  unit_t             norm_unit [CORNERS];

  ttf_norm u_norm (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (norm_start),
    .vec_in   (norm_vec),
    .done     (norm_done),
    .unit_out (norm_unit)
  );

  assign norm_vec[0] = raw_r[0];
  assign norm_vec[1] = raw_r[1];
  assign norm_vec[2] = raw_r[2];
  assign norm_start  = (state_r == S_NSTART) && !pend_r.valid;
  assign out_free    = !out_valid_r || !out_stall;
  assign out_load    = (state_r == S_FIN) && !pend_r.valid && out_free;
  assign tri_pop     = out_load && (corner_r == CORNER_LAST);
  assign out_valid   = out_valid_r;
  assign out_data    = out_r;

  // corner rotation
  always_comb begin
    unique case (corner_r)
      2'd1: begin
        vp = tri_data[1]; vq = tri_data[2]; vr = tri_data[0];
      end
      2'd2: begin
        vp = tri_data[2]; vq = tri_data[0]; vr = tri_data[1];
      end
      default: begin
        vp = tri_data[0]; vq = tri_data[1]; vr = tri_data[2];
      end
    endcase
  end

  // operand schedule of the shared multiplier
  always_comb begin
    opa       = '0;
    opb       = '0;
    iss.valid = 1'b0;
    iss.first = !step_r[0];
    iss.sub   = step_r[0];
    iss.store = step_r[0];
    iss.dest  = DST_RAW;
    unique case (state_r)
      S_RAW: begin
        iss.valid = 1'b1;
        unique case (step_r)
          5'd0:  begin opa = mop_t'(e2_r[1]); opb = mop_t'(e1_r[2]); end
          5'd1:  begin opa = mop_t'(e2_r[2]); opb = mop_t'(e1_r[1]); end
          5'd2:  begin opa = mop_t'(e2_r[2]); opb = mop_t'(e1_r[0]); end
          5'd3:  begin opa = mop_t'(e2_r[0]); opb = mop_t'(e1_r[2]); end
          5'd4:  begin opa = mop_t'(e2_r[0]); opb = mop_t'(e1_r[1]); end
          5'd5:  begin opa = mop_t'(e2_r[1]); opb = mop_t'(e1_r[0]); end
          5'd6:  begin opa = mop_t'(e1_r[0]); opb = mop_t'(dv2_r); end
          5'd7:  begin opa = mop_t'(e2_r[0]); opb = mop_t'(dv1_r); end
          5'd8:  begin opa = mop_t'(e1_r[1]); opb = mop_t'(dv2_r); end
          5'd9:  begin opa = mop_t'(e2_r[1]); opb = mop_t'(dv1_r); end
          5'd10: begin opa = mop_t'(e1_r[2]); opb = mop_t'(dv2_r); end
          5'd11: begin opa = mop_t'(e2_r[2]); opb = mop_t'(dv1_r); end
          5'd12: begin opa = mop_t'(e1_r[0]); opb = mop_t'(du2_r); end
          5'd13: begin opa = mop_t'(e2_r[0]); opb = mop_t'(du1_r); end
          5'd14: begin opa = mop_t'(e1_r[1]); opb = mop_t'(du2_r); end
          5'd15: begin opa = mop_t'(e2_r[1]); opb = mop_t'(du1_r); end
          5'd16: begin opa = mop_t'(e1_r[2]); opb = mop_t'(du2_r); end
          5'd17: begin opa = mop_t'(e2_r[2]); opb = mop_t'(du1_r); end
          default: begin end
        endcase
      end
      S_CROSS: begin
        // tangent cross binormal, tangent in slots 3..5 and binormal in 6..8
        iss.valid = 1'b1;
        iss.dest  = DST_CROSS;
        unique case (step_r)
          5'd0: begin opa = mop_t'(res_r[4]); opb = mop_t'(res_r[8]); end
          5'd1: begin opa = mop_t'(res_r[5]); opb = mop_t'(res_r[7]); end
          5'd2: begin opa = mop_t'(res_r[5]); opb = mop_t'(res_r[6]); end
          5'd3: begin opa = mop_t'(res_r[3]); opb = mop_t'(res_r[8]); end
          5'd4: begin opa = mop_t'(res_r[3]); opb = mop_t'(res_r[7]); end
          5'd5: begin opa = mop_t'(res_r[4]); opb = mop_t'(res_r[6]); end
          default: begin end
        endcase
      end
      S_DOT: begin
        // wait for the last cross term to land before using it
        iss.valid = (step_r != '0) || !pend_r.valid;
        iss.first = (step_r == '0);
        iss.sub   = 1'b0;
        iss.store = (step_r == STEP_W'(2));
        iss.dest  = DST_DOT;
        unique case (step_r)
          5'd0:    begin opa = c_r[0]; opb = mop_t'(res_r[0]); end
          5'd1:    begin opa = c_r[1]; opb = mop_t'(res_r[1]); end
          default: begin opa = c_r[2]; opb = mop_t'(res_r[2]); end
        endcase
      end
      default: begin end
    endcase
  end

  always_comb begin
    term    = pend_r.sub ? -raw_t'(prod_r) : raw_t'(prod_r);
    acc_nxt = pend_r.first ? term : acc_r + term;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (tri_valid) state_nxt = S_EDGE;
      S_EDGE:   state_nxt = S_RAW;
      S_RAW:    if (step_r == STEP_W'(RAW_STEPS - 1)) state_nxt = S_NSTART;
      S_NSTART: if (!pend_r.valid) state_nxt = S_NWAIT;
      S_NWAIT: begin
        if (norm_done) state_nxt = (nidx_r == CORNER_LAST) ? S_CROSS : S_NSTART;
      end
      S_CROSS:  if (step_r == STEP_W'(5)) state_nxt = S_DOT;
      S_DOT:    if (iss.valid && step_r == STEP_W'(2)) state_nxt = S_FIN;
      S_FIN: begin
        if (out_load) state_nxt = (corner_r == CORNER_LAST) ? S_IDLE : S_EDGE;
      end
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      pend_r       <= '0;
      out_valid_r  <= 1'b0;
      corner_r     <= '0;
      nidx_r       <= '0;
      step_r       <= '0;
    end else begin
      state_r      <= state_nxt;
      pend_r       <= iss;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == S_IDLE) begin
        corner_r <= '0;
      end else if (out_load) begin
        corner_r <= corner_r + 2'd1;
      end
      if (state_r == S_NWAIT && norm_done) begin
        nidx_r <= (nidx_r == CORNER_LAST) ? 2'd0 : nidx_r + 2'd1;
      end
      if (state_r == S_EDGE || (state_r != state_nxt)) begin
        step_r <= '0;
      end else if (iss.valid) begin
        step_r <= step_r + STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_EDGE) begin
      e1_r[0] <= edge_t'(vp.pos_x) - edge_t'(vq.pos_x);
      e1_r[1] <= edge_t'(vp.pos_y) - edge_t'(vq.pos_y);
      e1_r[2] <= edge_t'(vp.pos_z) - edge_t'(vq.pos_z);
      e2_r[0] <= edge_t'(vr.pos_x) - edge_t'(vp.pos_x);
      e2_r[1] <= edge_t'(vr.pos_y) - edge_t'(vp.pos_y);
      e2_r[2] <= edge_t'(vr.pos_z) - edge_t'(vp.pos_z);
      du1_r   <= edge_t'(vp.tex_u) - edge_t'(vq.tex_u);
      du2_r   <= edge_t'(vr.tex_u) - edge_t'(vp.tex_u);
      dv1_r   <= edge_t'(vp.tex_v) - edge_t'(vq.tex_v);
      dv2_r   <= edge_t'(vr.tex_v) - edge_t'(vp.tex_v);
    end

    prod_r <= opa * opb;
    if (pend_r.valid) begin
      acc_r <= acc_nxt;
    end

    // raw vectors enter at the top and drain three at a time to the normaliser
    if (pend_r.valid && pend_r.store && pend_r.dest == DST_RAW) begin
      for (int i = 0; i < RAW_VECS - 1; i++) begin
        raw_r[i] <= raw_r[i+1];
      end
      raw_r[RAW_VECS-1] <= acc_nxt;
    end else if (norm_start) begin
      for (int i = 0; i < RAW_VECS - CORNERS; i++) begin
        raw_r[i] <= raw_r[i+CORNERS];
      end
    end

    if (pend_r.valid && pend_r.store && pend_r.dest == DST_CROSS) begin
      c_r[0] <= c_r[1];
      c_r[1] <= c_r[2];
      c_r[2] <= mop_t'(acc_nxt[MUL_W-1:0]);
    end

    if (pend_r.valid && pend_r.store && pend_r.dest == DST_DOT) begin
      neg_r <= acc_nxt[RAW_W-1];
    end

    // normal lands in slots 0..2, tangent 3..5, binormal 6..8
    if (state_r == S_NWAIT && norm_done) begin
      for (int i = 0; i < RAW_VECS - CORNERS; i++) begin
        res_r[i] <= res_r[i+CORNERS];
      end
      for (int i = 0; i < CORNERS; i++) begin
        res_r[RAW_VECS-CORNERS+i] <= norm_unit[i];
      end
    end

    if (out_load) begin
      out_r.corner <= corner_r;
      out_r.last   <= (corner_r == CORNER_LAST);
      out_r.norm_x <= res_r[0];
      out_r.norm_y <= res_r[1];
      out_r.norm_z <= res_r[2];
      out_r.tan_x  <= neg_r ? -res_r[3] : res_r[3];
      out_r.tan_y  <= neg_r ? -res_r[4] : res_r[4];
      out_r.tan_z  <= neg_r ? -res_r[5] : res_r[5];
      out_r.bin_x  <= neg_r ? -res_r[6] : res_r[6];
      out_r.bin_y  <= neg_r ? -res_r[7] : res_r[7];
      out_r.bin_z  <= neg_r ? -res_r[8] : res_r[8];
    end
  end

  `TTF_ASSERT_NOW(a_pop_has_tri, tri_pop, tri_valid, "triangle retired with none queued")
  `TTF_ASSERT_NOW(a_corner_range, out_valid_r, out_r.corner != 2'd3, "frame corner out of range")
  `TTF_ASSERT_NOW(a_last_matches, out_valid_r, out_r.last == (out_r.corner == CORNER_LAST),
                  "last flag does not match the closing corner")

endmodule

/* rtl/triangle_tangent_frame_unit.sv */
// ----------------------------------------------------------------------------
// triangle_tangent_frame_unit
// per-corner normal, tangent and binormal of a triangle-list vertex stream
// ----------------------------------------------------------------------------
// Usage: vertices arrive on in_data (position and texture coordinate, signed
// Q16.16) under in_valid/in_stall; a vertex is taken when in_valid is high and
// in_stall is low. Every third vertex closes a triangle, which then yields
// three requests on out_data (corners 0, 1, 2, last set on corner 2), each a
// unit normal and handedness-corrected tangent and binormal in signed Q1.14.
// Vertex capture runs ahead of the frame engine through a two-triangle queue,
// so in_stall only rises on a closing vertex while that queue is full.
// Frame time is set by the normaliser, and is shorter when a vector is zero:
// three passes per frame, each a leading-zero shift, a 31-step square root
// and a 15-step divide, plus the work on the shared multiplier.
// Reset (rst_n low, synchronous) empties the queue, drops any partial
// triangle and clears out_valid. While out_stall is high the current frame
// stays on out_data and the engine parks the next one until the slot frees.
// ----------------------------------------------------------------------------
module triangle_tangent_frame_unit import ttf_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  ttf_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output ttf_out_t out_data
);

  logic     tri_push, q_full, tri_pop, tri_valid;
  ttf_tri_t push_data, head_data;

  ttf_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .tri_push (tri_push),
    .tri_data (push_data),
    .q_full   (q_full)
  );

  ttf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (tri_push),
    .push_data  (push_data),
    .full       (q_full),
    .pop        (tri_pop),
    .head_valid (tri_valid),
    .head_data  (head_data)
  );

  ttf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .tri_valid (tri_valid),
    .tri_data  (head_data),
    .tri_pop   (tri_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

/* verif/testbench.sv */
// ----------------------------------------------------------------------------
// triangle tangent frame unit testbench
// drives triangle-list vertices with random gaps and back-pressure, predicts
// the three corner frames of every triangle and checks each output request
// ----------------------------------------------------------------------------
module testbench import ttf_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [127:0] wide_t;
  typedef logic [63:0] u64_t;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 1000;

  class frame_scoreboard;
    ttf_out_t expected_frames[$];
    longint held_pos[2][3];
    longint held_tex[2][2];
    int vertex_slot;
    int mismatches;

    function new();
      vertex_slot = 0;
      mismatches = 0;
    endfunction

    function u64_t int_sqrt(u64_t s);
      u64_t res;
      u64_t bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > s) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (s >= res + bitv) begin
          s = s - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      return res;
    endfunction

    function void unit_vector(input wide_t v[3], output longint o[3]);
      logic [127:0] mag[3];
      bit sgn[3];
      u64_t m[3];
      u64_t sum;
      u64_t len;
      u64_t q;
      int lmax;
      lmax = 0;
      sum = 0;
      for (int i = 0; i < 3; i++) begin
        sgn[i] = v[i][127];
        mag[i] = sgn[i] ? -v[i] : v[i];
        for (int b = 127; b >= 0; b--) begin
          if (mag[i][b]) begin
            if (b + 1 > lmax) lmax = b + 1;
            break;
          end
        end
      end
      if (lmax == 0) begin
        for (int i = 0; i < 3; i++) o[i] = 0;
        return;
      end
      for (int i = 0; i < 3; i++) begin
        if (lmax > NORM_W) m[i] = u64_t'(mag[i] >> (lmax - NORM_W));
        else m[i] = u64_t'(mag[i] << (NORM_W - lmax));
        sum += m[i] * m[i];
      end
      len = int_sqrt(sum);
      for (int i = 0; i < 3; i++) begin
        q = ((m[i] << (FRAC_W + 1)) + len) / (2 * len);
        o[i] = sgn[i] ? -longint'(q) : longint'(q);
      end
    endfunction

    function void corner_frame(input longint p[3][3], input longint t[3][2],
                               input int a, input int b, input int c,
                               output longint nrm[3], output longint tng[3],
                               output longint bnm[3]);
      longint e1[3];
      longint e2[3];
      longint du1, du2, dv1, dv2, dot, cr;
      wide_t rn[3], rt[3], rb[3];
      int j, k;
      du1 = t[a][0] - t[b][0];
      du2 = t[c][0] - t[a][0];
      dv1 = t[a][1] - t[b][1];
      dv2 = t[c][1] - t[a][1];
      for (int i = 0; i < 3; i++) begin
        e1[i] = p[a][i] - p[b][i];
        e2[i] = p[c][i] - p[a][i];
      end
      for (int i = 0; i < 3; i++) begin
        j = (i + 1) % 3;
        k = (i + 2) % 3;
        rn[i] = wide_t'(e2[j]) * wide_t'(e1[k]) - wide_t'(e2[k]) * wide_t'(e1[j]);
        rb[i] = wide_t'(e1[i]) * wide_t'(du2) - wide_t'(e2[i]) * wide_t'(du1);
        rt[i] = wide_t'(e1[i]) * wide_t'(dv2) - wide_t'(e2[i]) * wide_t'(dv1);
      end
      unit_vector(rn, nrm);
      unit_vector(rt, tng);
      unit_vector(rb, bnm);
      dot = 0;
      for (int i = 0; i < 3; i++) begin
        j = (i + 1) % 3;
        k = (i + 2) % 3;
        cr = tng[j] * bnm[k] - tng[k] * bnm[j];
        dot += cr * nrm[i];
      end
      // mirrored mapping flips handedness
      if (dot < 0) begin
        for (int i = 0; i < 3; i++) begin
          tng[i] = -tng[i];
          bnm[i] = -bnm[i];
        end
      end
    endfunction

    function void note_vertex(ttf_in_t v);
      longint p[3][3];
      longint t[3][2];
      longint nrm[3], tng[3], bnm[3];
      ttf_out_t f;
      if (vertex_slot < 2) begin
        held_pos[vertex_slot][0] = v.pos_x;
        held_pos[vertex_slot][1] = v.pos_y;
        held_pos[vertex_slot][2] = v.pos_z;
        held_tex[vertex_slot][0] = v.tex_u;
        held_tex[vertex_slot][1] = v.tex_v;
        vertex_slot++;
        return;
      end
      for (int n = 0; n < 2; n++) begin
        for (int i = 0; i < 3; i++) p[n][i] = held_pos[n][i];
        for (int i = 0; i < 2; i++) t[n][i] = held_tex[n][i];
      end
      p[2][0] = v.pos_x;
      p[2][1] = v.pos_y;
      p[2][2] = v.pos_z;
      t[2][0] = v.tex_u;
      t[2][1] = v.tex_v;
      vertex_slot = 0;
      for (int n = 0; n < CORNERS; n++) begin
        corner_frame(p, t, n, (n + 1) % 3, (n + 2) % 3, nrm, tng, bnm);
        f.corner = 2'(n);
        f.last = (n == CORNERS - 1);
        f.norm_x = unit_t'(nrm[0]);
        f.norm_y = unit_t'(nrm[1]);
        f.norm_z = unit_t'(nrm[2]);
        f.tan_x = unit_t'(tng[0]);
        f.tan_y = unit_t'(tng[1]);
        f.tan_z = unit_t'(tng[2]);
        f.bin_x = unit_t'(bnm[0]);
        f.bin_y = unit_t'(bnm[1]);
        f.bin_z = unit_t'(bnm[2]);
        expected_frames.insert(expected_frames.size(), f);
      end
    endfunction

    function void check_frame(ttf_out_t act);
      ttf_out_t exp_f;
      longint ev[11];
      longint av[11];
      string names[11];
      bit bad;
      if (expected_frames.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected request: %p", act);
        return;
      end
      exp_f = expected_frames.pop_front();
      names = '{"corner", "last", "norm_x", "norm_y", "norm_z", "tan_x", "tan_y",
                "tan_z", "bin_x", "bin_y", "bin_z"};
      ev = '{exp_f.corner, exp_f.last, exp_f.norm_x, exp_f.norm_y, exp_f.norm_z,
             exp_f.tan_x, exp_f.tan_y, exp_f.tan_z, exp_f.bin_x, exp_f.bin_y,
             exp_f.bin_z};
      av = '{act.corner, act.last, act.norm_x, act.norm_y, act.norm_z,
             act.tan_x, act.tan_y, act.tan_z, act.bin_x, act.bin_y, act.bin_z};
      bad = 0;
      for (int i = 0; i < 11; i++) begin
        if (ev[i] != av[i]) begin
          bad = 1;
          if (mismatches < 10)
            $display("mismatch on %s: expected %0d, got %0d", names[i], ev[i], av[i]);
        end
      end
      if (bad) mismatches++;
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  ttf_in_t in_data;
  logic out_valid;
  logic out_stall;
  ttf_out_t out_data;

  int send_idle;
  int recv_idle;
  int cycle_count;
  frame_scoreboard sb;

  triangle_tangent_frame_unit u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  initial clk = 0;
  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(negedge clk) begin
    out_stall = ($urandom_range(0, 99) < recv_idle);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_frame(out_data);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic send_vertex(ttf_in_t v);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid = 0;
      @(negedge clk);
    end
    in_valid = 1;
    in_data = v;
    do @(posedge clk); while (in_stall);
    sb.note_vertex(v);
  endtask

  function automatic ttf_in_t vertex(longint px, longint py, longint pz,
                                     longint tu, longint tv);
    ttf_in_t v;
    v.pos_x = coord_t'(px);
    v.pos_y = coord_t'(py);
    v.pos_z = coord_t'(pz);
    v.tex_u = coord_t'(tu);
    v.tex_v = coord_t'(tv);
    return v;
  endfunction

  function automatic coord_t rand_coord(bit narrow);
    if (narrow) return coord_t'(int'($urandom_range(0, 2097152)) - 1048576);
    return coord_t'($urandom);
  endfunction

  task automatic send_random_triangle();
    bit narrow;
    ttf_in_t v;
    narrow = ($urandom_range(0, 3) != 0);
    for (int n = 0; n < 3; n++) begin
      v.pos_x = rand_coord(narrow);
      v.pos_y = rand_coord(narrow);
      v.pos_z = rand_coord(narrow);
      v.tex_u = rand_coord(narrow);
      v.tex_v = rand_coord(narrow);
      send_vertex(v);
    end
  endtask

  task automatic wait_drained();
    while (sb.expected_frames.size() != 0) @(posedge clk);
  endtask

  localparam longint CMAX = 64'sd2147483647;
  localparam longint CMIN = -64'sd2147483648;
  localparam longint ONE = 64'sd65536;

  initial begin
    sb = new();
    cycle_count = 0;
    rst_n = 0;
    in_valid = 0;
    in_data = '0;
    out_stall = 0;
    send_idle = 15;
    recv_idle = 88;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // degenerate triangle, all zero
    for (int n = 0; n < 3; n++) send_vertex(vertex(0, 0, 0, 0, 0));
    // coordinate extremes
    send_vertex(vertex(CMAX, CMIN, 0, CMAX, CMIN));
    send_vertex(vertex(CMIN, CMAX, CMAX, CMIN, 0));
    send_vertex(vertex(0, 0, CMIN, 0, CMAX));
    // plain unit triangle
    send_vertex(vertex(0, 0, 0, 0, 0));
    send_vertex(vertex(ONE, 0, 0, ONE, 0));
    send_vertex(vertex(0, ONE, 0, 0, ONE));
    // mirrored mapping, handedness flips
    send_vertex(vertex(0, 0, 0, 0, 0));
    send_vertex(vertex(ONE, 0, 0, -ONE, 0));
    send_vertex(vertex(0, ONE, 0, 0, ONE));
    // flat texture mapping, zero tangent and binormal, zero sign test
    send_vertex(vertex(0, 0, 0, 5, 5));
    send_vertex(vertex(3 * ONE, ONE, 0, 5, 5));
    send_vertex(vertex(ONE, 7 * ONE, 2 * ONE, 5, 5));
    // collinear positions
    send_vertex(vertex(0, 0, 0, 0, 0));
    send_vertex(vertex(ONE, ONE, ONE, ONE, 0));
    send_vertex(vertex(2 * ONE, 2 * ONE, 2 * ONE, 0, ONE));
    // all at the top and bottom of range
    send_vertex(vertex(CMAX, CMAX, CMAX, CMAX, CMAX));
    send_vertex(vertex(CMIN, CMIN, CMIN, CMIN, CMIN));
    send_vertex(vertex(CMAX, CMIN, CMAX, CMIN, CMAX));

    for (int n = 0; n < 11; n++) send_random_triangle();
    send_idle = 88;
    recv_idle = 15;
    for (int n = 0; n < 11; n++) send_random_triangle();
    send_idle = 0;
    recv_idle = 0;
    for (int n = 0; n < 11; n++) send_random_triangle();
    @(negedge clk);
    in_valid = 0;

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_frames.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
